FILE: sv/orsi_pkg.sv
// orsi_pkg: fault codes shared by the rate step increment unit and its channels
// depends on nothing
`default_nettype none
package orsi_pkg;
  typedef logic [1:0] fault_t;
  localparam fault_t FAULT_OK          = 2'd0;
  localparam fault_t FAULT_ZERO_RADIUS = 2'd1;
  localparam fault_t FAULT_SATURATED   = 2'd2;
endpackage
`default_nettype wire

FILE: sv/orsi_if.sv
// orsi_in_if / orsi_out_if: valid/ready channels of the rate step increment unit
// depends on orsi_pkg
`default_nettype none
interface orsi_in_if #(parameter int W = 64);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] step_size;
  logic        [W-2:0] radius;
  logic signed [W-1:0] height;
  logic signed [W-1:0] radial_speed;
  logic signed [W-1:0] tangential_speed;
  logic signed [W-1:0] vertical_speed;
  modport source (output valid, step_size, radius, height, radial_speed,
                  tangential_speed, vertical_speed, input ready);
  modport sink (input valid, step_size, radius, height, radial_speed,
                tangential_speed, vertical_speed, output ready);
endinterface

interface orsi_out_if #(parameter int W = 64);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] k_radius;
  logic signed [W-1:0] k_angle;
  logic signed [W-1:0] k_height;
  logic signed [W-1:0] k_radial_speed;
  logic signed [W-1:0] k_tangential_speed;
  logic signed [W-1:0] k_vertical_speed;
  orsi_pkg::fault_t    fault_code;
  modport source (output valid, k_radius, k_angle, k_height, k_radial_speed,
                  k_tangential_speed, k_vertical_speed, fault_code, input ready);
  modport sink (input valid, k_radius, k_angle, k_height, k_radial_speed,
                k_tangential_speed, k_vertical_speed, fault_code, output ready);
endinterface
`default_nettype wire

FILE: sv/orsi_mul.sv
// orsi_mul: two-stage unsigned magnitude multiplier from four half-width partials
// sign is xor of operand signs; sideband travels with the item; no package use
`default_nettype none
module orsi_mul #(
  parameter int W      = 64,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic              a_neg_i,
  input  wire logic              b_neg_i,
  input  wire logic [W-1:0]      a_i,
  input  wire logic [W-1:0]      b_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic                   neg_o,
  output logic [2*W-1:0]         p_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int L  = W / 2;
  localparam int U  = W - L;
  localparam int PW = 2 * W;

  logic [2*L-1:0]    pp00_nxt, pp00_r;
  logic [W-1:0]      pp01_nxt, pp01_r;
  logic [W-1:0]      pp10_nxt, pp10_r;
  logic [2*U-1:0]    pp11_nxt, pp11_r;
  logic              neg1_r;
  logic [SIDE_W-1:0] side1_r;
  logic              vld1_r, vld2_r;
  logic [PW-1:0]     p_nxt, p_r;
  logic              neg2_r;
  logic [SIDE_W-1:0] side2_r;

  // partial products
  assign pp00_nxt = a_i[L-1:0] * b_i[L-1:0];
  assign pp01_nxt = a_i[L-1:0] * b_i[W-1:L];
  assign pp10_nxt = a_i[W-1:L] * b_i[L-1:0];
  assign pp11_nxt = a_i[W-1:L] * b_i[W-1:L];

  // partial product sum
  assign p_nxt = {pp11_r, pp00_r} + (PW'(pp01_r) << L) + (PW'(pp10_r) << L);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r  <= pp00_nxt;
      pp01_r  <= pp01_nxt;
      pp10_r  <= pp10_nxt;
      pp11_r  <= pp11_nxt;
      neg1_r  <= a_neg_i ^ b_neg_i;
      side1_r <= side_i;
      p_r     <= p_nxt;
      neg2_r  <= neg1_r;
      side2_r <= side1_r;
    end
  end

  assign vld_o  = vld2_r;
  assign neg_o  = neg2_r;
  assign p_o    = p_r;
  assign side_o = side2_r;
endmodule
`default_nettype wire

FILE: sv/orsi_div.sv
// orsi_div: pipelined restoring divider, (|a| << F) / |b|, one quotient bit per stage
// clamps to the signed word range and flags it; a zero divisor gives zero, also flagged; no package use
`default_nettype none
module orsi_div #(
  parameter int W      = 64,
  parameter int F      = 40,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic              a_neg_i,
  input  wire logic [W-1:0]      a_mag_i,
  input  wire logic              b_neg_i,
  input  wire logic [W-1:0]      b_mag_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic                   q_neg_o,
  output logic [W-1:0]           q_mag_o,
  output logic                   q_sat_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic [W-1:0]      rem_r  [0:W-1];
  logic [W-1:0]      b_r    [0:W-1];
  logic [W-1:0]      num_r  [0:W];
  logic              neg_r  [0:W];
  logic              ovf_r  [0:W];
  logic              zb_r   [0:W];
  logic [SIDE_W-1:0] side_r [0:W];
  logic [W+1:0]      vld_r;
  logic [W-1:0]      cap;
  logic              q_neg_r, q_sat_r;
  logic [W-1:0]      q_mag_r;
  logic [SIDE_W-1:0] q_side_r;

  // valid bits through all stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[W:0], vld_i};
    end
  end

  // entry stage: high quotient bits decide overflow up front
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= a_mag_i >> (W - F);
      num_r[0]  <= a_mag_i << F;
      b_r[0]    <= b_mag_i;
      neg_r[0]  <= a_neg_i ^ b_neg_i;
      ovf_r[0]  <= (a_mag_i >> (W - F)) >= b_mag_i;
      zb_r[0]   <= (b_mag_i == '0);
      side_r[0] <= side_i;
    end
  end

  // one quotient bit per stage, shifted into the numerator register
  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [W:0] t;
    logic [W:0] diff;
    logic       ge;
    assign t    = {rem_r[k-1], num_r[k-1][W-1]};
    assign diff = t - {1'b0, b_r[k-1]};
    assign ge   = !diff[W];
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k]  <= {num_r[k-1][W-2:0], ge};
        neg_r[k]  <= neg_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        zb_r[k]   <= zb_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
    if (k < W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[W-1:0] : t[W-1:0];
          b_r[k]   <= b_r[k-1];
        end
      end
    end
  end

  // clamp and sign
  assign cap = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg_r[W]};

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (zb_r[W]) begin
        q_mag_r <= '0;
        q_sat_r <= 1'b1;
        q_neg_r <= 1'b0;
      end else if (ovf_r[W] || (num_r[W] > cap)) begin
        q_mag_r <= cap;
        q_sat_r <= 1'b1;
        q_neg_r <= neg_r[W];
      end else begin
        q_mag_r <= num_r[W];
        q_sat_r <= 1'b0;
        q_neg_r <= neg_r[W] && (num_r[W] != '0);
      end
      q_side_r <= side_r[W];
    end
  end

  assign vld_o   = vld_r[W+1];
  assign q_neg_o = q_neg_r;
  assign q_mag_o = q_mag_r;
  assign q_sat_o = q_sat_r;
  assign side_o  = q_side_r;
endmodule
`default_nettype wire

FILE: sv/orsi_sqrt.sv
// orsi_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
// 2W-bit radicand, W-bit floor root; no package use
`default_nettype none
module orsi_sqrt #(
  parameter int W      = 64,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [2*W-1:0]    rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [W-1:0]           root_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int RW = W + 3;

  logic [2*W-1:0]    rad_r  [0:W-1];
  logic [RW-1:0]     rem_r  [0:W-1];
  logic [W-1:0]      root_r [0:W];
  logic [SIDE_W-1:0] side_r [0:W];
  logic [W:0]        vld_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[W-1:0], vld_i};
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= rad_i;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= side_i;
    end
  end

  // two radicand bits in, one root bit out per stage
  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;
    assign t     = {rem_r[k-1][RW-3:0], rad_r[k-1][2*W-1:2*W-2]};
    assign trial = {1'b0, root_r[k-1], 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_r[k-1][W-2:0], ge};
        side_r[k] <= side_r[k-1];
      end
    end
    if (k < W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (t - trial) : t;
          rad_r[k] <= rad_r[k-1] << 2;
        end
      end
    end
  end

  assign vld_o  = vld_r[W];
  assign root_o = root_r[W];
  assign side_o = side_r[W];
endmodule
`default_nettype wire

FILE: sv/orbital_rate_step_increment_unit.sv
// orbital_rate_step_increment_unit: step-scaled two-body cylindrical rates
// depends on orsi_pkg, orsi_if, orsi_mul, orsi_div, orsi_sqrt
//
//  channel | dir | signals
//  in_ch   | in  | valid/ready, step_size, radius, height, three speeds
//  out_ch  | out | valid/ready, six k_* increments, fault_code
//  cfg     | in  | cfg_wr_en, cfg_wr_data (grav_parameter)
//
// one item per cycle while out_ch takes results; the depth of the pipe is
// set by the root pipeline and the two chained divider pipelines
// rst_n synchronous: clears valid bits and grav_parameter
// all stages advance together; when the output holds an untaken item the
// whole pipe holds and in_ch.ready drops, so nothing is lost or repeated
`default_nettype none
module orbital_rate_step_increment_unit #(
  parameter int WORD_BITS     = 64,
  parameter int FRACTION_BITS = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [WORD_BITS-2:0] cfg_wr_data,
  orsi_in_if.sink                   in_ch,
  orsi_out_if.source                out_ch
);
  localparam int W = WORD_BITS;
  localparam int F = FRACTION_BITS;

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } sv_t;

  typedef struct packed {
    logic         sat;
    logic         neg;
    logic [W-1:0] mag;
  } sq_t;

  typedef struct packed {
    logic         zr;
    sv_t          h;
    logic [W-1:0] r_m;
    sv_t          z;
    sv_t          vr;
    sv_t          vt;
    sv_t          vz;
    logic [W-1:0] gm_m;
  } st_a_t;

  typedef struct packed {
    logic         zr;
    sv_t          h;
    sv_t          vr;
    sv_t          vt;
    sv_t          vz;
    logic [W-1:0] d_m;
  } st_b_t;

  typedef struct packed {
    logic zr;
    logic sat;
    sv_t  h;
    sv_t  vr;
    sv_t  vt;
    sv_t  vz;
    sv_t  w;
    sv_t  qr;
    sv_t  qz;
  } st_c_t;

  typedef struct packed {
    logic zr;
    logic sat;
    sv_t  h;
  } st_d_t;

  typedef struct packed {
    logic zr;
    logic sat;
    sv_t  k0;
    sv_t  k1;
    sv_t  k2;
  } st_e_t;

  // clamp to the signed word range
  function automatic sq_t mk(input logic neg, input logic [W-1:0] mag, input logic over);
    sq_t          res;
    logic [W-1:0] cap;
    cap = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg};
    if (over || (mag > cap)) begin
      res.sat = 1'b1;
      res.mag = cap;
    end else begin
      res.sat = 1'b0;
      res.mag = mag;
    end
    res.neg = neg && (res.mag != '0);
    return res;
  endfunction

  // drop fraction bits of a full product
  function automatic sq_t quant(input logic neg, input logic [2*W-1:0] p);
    return mk(neg, p[F+W-1:F], |p[2*W-1:F+W]);
  endfunction

  function automatic sq_t negq(input sq_t a);
    return mk(!a.neg, a.mag, 1'b0);
  endfunction

  function automatic sq_t addq(input sq_t a, input sq_t b);
    logic [W:0] s;
    sq_t        res;
    s = {1'b0, a.mag} + {1'b0, b.mag};
    priority if (a.neg == b.neg) begin
      res = mk(a.neg, s[W-1:0], s[W]);
    end else if (a.mag >= b.mag) begin
      res = mk(a.neg, a.mag - b.mag, 1'b0);
    end else begin
      res = mk(b.neg, b.mag - a.mag, 1'b0);
    end
    return res;
  endfunction

  function automatic sv_t from_in(input logic [W-1:0] v);
    sv_t res;
    res.neg = v[W-1];
    res.mag = v[W-1] ? (W'(0) - v) : v;
    return res;
  endfunction

  function automatic sv_t to_sv(input sq_t a);
    sv_t res;
    res.neg = a.neg;
    res.mag = a.mag;
    return res;
  endfunction

  function automatic logic [W-1:0] to_out(input sq_t a);
    return a.neg ? (W'(0) - a.mag) : a.mag;
  endfunction

  logic         en;
  logic [W-2:0] gm_r;
  logic         s0_vld_r;
  st_a_t        s0_r, s0_nxt;

  // global advance: the output register frees up or is empty
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // grav_parameter register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r <= '0;
    end else if (cfg_wr_en) begin
      gm_r <= cfg_wr_data;
    end
  end

  // input stage: sign and magnitude
  always_comb begin
    s0_nxt.zr   = (in_ch.radius == '0);
    s0_nxt.h    = from_in(in_ch.step_size);
    s0_nxt.r_m  = {1'b0, in_ch.radius};
    s0_nxt.z    = from_in(in_ch.height);
    s0_nxt.vr   = from_in(in_ch.radial_speed);
    s0_nxt.vt   = from_in(in_ch.tangential_speed);
    s0_nxt.vz   = from_in(in_ch.vertical_speed);
    s0_nxt.gm_m = {1'b0, gm_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // r squared and z squared
  logic           m1_vld;
  logic [2*W-1:0] prr, pzz;
  st_a_t          side_m1;

  orsi_mul #(.W(W), .SIDE_W($bits(st_a_t))) u_mul_rr (
    .clk, .rst_n, .en, .vld_i(s0_vld_r), .a_neg_i(1'b0), .b_neg_i(1'b0),
    .a_i(s0_r.r_m), .b_i(s0_r.r_m), .side_i(s0_r),
    .vld_o(m1_vld), .neg_o(), .p_o(prr), .side_o(side_m1)
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_zz (
    .clk, .rst_n, .en, .vld_i(s0_vld_r), .a_neg_i(1'b0), .b_neg_i(1'b0),
    .a_i(s0_r.z.mag), .b_i(s0_r.z.mag), .side_i(1'b0),
    .vld_o(), .neg_o(), .p_o(pzz), .side_o()
  );

  // radicand sum
  logic           s2_vld_r;
  logic [2*W-1:0] rad_r;
  st_a_t          s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= prr + pzz;
      s2_r  <= side_m1;
    end
  end

  // distance
  logic         sq_vld;
  logic [W-1:0] d_m;
  st_a_t        side_sq;

  orsi_sqrt #(.W(W), .SIDE_W($bits(st_a_t))) u_sqrt (
    .clk, .rst_n, .en, .vld_i(s2_vld_r), .rad_i(rad_r), .side_i(s2_r),
    .vld_o(sq_vld), .root_o(d_m), .side_o(side_sq)
  );

  // first divider bank: vt/r, r/d, z/d, gm/d
  st_b_t        side_b_in, side_b;
  logic         dv1_vld;
  sq_t          w_q, qr_q, qz_q, g1_q;

  always_comb begin
    side_b_in.zr  = side_sq.zr;
    side_b_in.h   = side_sq.h;
    side_b_in.vr  = side_sq.vr;
    side_b_in.vt  = side_sq.vt;
    side_b_in.vz  = side_sq.vz;
    side_b_in.d_m = d_m;
  end

  orsi_div #(.W(W), .F(F), .SIDE_W($bits(st_b_t))) u_div_w (
    .clk, .rst_n, .en, .vld_i(sq_vld),
    .a_neg_i(side_sq.vt.neg), .a_mag_i(side_sq.vt.mag),
    .b_neg_i(1'b0), .b_mag_i(side_sq.r_m), .side_i(side_b_in),
    .vld_o(dv1_vld), .q_neg_o(w_q.neg), .q_mag_o(w_q.mag), .q_sat_o(w_q.sat),
    .side_o(side_b)
  );

  orsi_div #(.W(W), .F(F), .SIDE_W(1)) u_div_qr (
    .clk, .rst_n, .en, .vld_i(sq_vld),
    .a_neg_i(1'b0), .a_mag_i(side_sq.r_m),
    .b_neg_i(1'b0), .b_mag_i(d_m), .side_i(1'b0),
    .vld_o(), .q_neg_o(qr_q.neg), .q_mag_o(qr_q.mag), .q_sat_o(qr_q.sat),
    .side_o()
  );

  orsi_div #(.W(W), .F(F), .SIDE_W(1)) u_div_qz (
    .clk, .rst_n, .en, .vld_i(sq_vld),
    .a_neg_i(side_sq.z.neg), .a_mag_i(side_sq.z.mag),
    .b_neg_i(1'b0), .b_mag_i(d_m), .side_i(1'b0),
    .vld_o(), .q_neg_o(qz_q.neg), .q_mag_o(qz_q.mag), .q_sat_o(qz_q.sat),
    .side_o()
  );

  orsi_div #(.W(W), .F(F), .SIDE_W(1)) u_div_g1 (
    .clk, .rst_n, .en, .vld_i(sq_vld),
    .a_neg_i(1'b0), .a_mag_i(side_sq.gm_m),
    .b_neg_i(1'b0), .b_mag_i(d_m), .side_i(1'b0),
    .vld_o(), .q_neg_o(g1_q.neg), .q_mag_o(g1_q.mag), .q_sat_o(g1_q.sat),
    .side_o()
  );

  // second divider: g2 = g1/d
  st_c_t side_c_in, side_c;
  logic  dv2_vld;
  sq_t   g2_q;

  always_comb begin
    side_c_in.zr  = side_b.zr;
    side_c_in.sat = w_q.sat | qr_q.sat | qz_q.sat | g1_q.sat;
    side_c_in.h   = side_b.h;
    side_c_in.vr  = side_b.vr;
    side_c_in.vt  = side_b.vt;
    side_c_in.vz  = side_b.vz;
    side_c_in.w   = to_sv(w_q);
    side_c_in.qr  = to_sv(qr_q);
    side_c_in.qz  = to_sv(qz_q);
  end

  orsi_div #(.W(W), .F(F), .SIDE_W($bits(st_c_t))) u_div_g2 (
    .clk, .rst_n, .en, .vld_i(dv1_vld),
    .a_neg_i(g1_q.neg), .a_mag_i(g1_q.mag),
    .b_neg_i(1'b0), .b_mag_i(side_b.d_m), .side_i(side_c_in),
    .vld_o(dv2_vld), .q_neg_o(g2_q.neg), .q_mag_o(g2_q.mag), .q_sat_o(g2_q.sat),
    .side_o(side_c)
  );

  // product bank: gravity components, coupling terms, first three increments
  st_d_t          side_d_in, side_d;
  logic           m6_vld;
  logic           n_ar, n_az, n_tw, n_vrw, n_k0, n_k1, n_k2;
  logic [2*W-1:0] p_ar, p_az, p_tw, p_vrw, p_k0, p_k1, p_k2;

  always_comb begin
    side_d_in.zr  = side_c.zr;
    side_d_in.sat = side_c.sat | g2_q.sat;
    side_d_in.h   = side_c.h;
  end

  orsi_mul #(.W(W), .SIDE_W($bits(st_d_t))) u_mul_k0 (
    .clk, .rst_n, .en, .vld_i(dv2_vld), .a_neg_i(side_c.h.neg), .b_neg_i(side_c.vr.neg),
    .a_i(side_c.h.mag), .b_i(side_c.vr.mag), .side_i(side_d_in),
    .vld_o(m6_vld), .neg_o(n_k0), .p_o(p_k0), .side_o(side_d)
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_k1 (
    .clk, .rst_n, .en, .vld_i(dv2_vld), .a_neg_i(side_c.h.neg), .b_neg_i(side_c.w.neg),
    .a_i(side_c.h.mag), .b_i(side_c.w.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_k1), .p_o(p_k1), .side_o()
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_k2 (
    .clk, .rst_n, .en, .vld_i(dv2_vld), .a_neg_i(side_c.h.neg), .b_neg_i(side_c.vz.neg),
    .a_i(side_c.h.mag), .b_i(side_c.vz.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_k2), .p_o(p_k2), .side_o()
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_ar (
    .clk, .rst_n, .en, .vld_i(dv2_vld), .a_neg_i(g2_q.neg), .b_neg_i(side_c.qr.neg),
    .a_i(g2_q.mag), .b_i(side_c.qr.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_ar), .p_o(p_ar), .side_o()
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_az (
    .clk, .rst_n, .en, .vld_i(dv2_vld), .a_neg_i(g2_q.neg), .b_neg_i(side_c.qz.neg),
    .a_i(g2_q.mag), .b_i(side_c.qz.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_az), .p_o(p_az), .side_o()
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_tw (
    .clk, .rst_n, .en, .vld_i(dv2_vld), .a_neg_i(side_c.vt.neg), .b_neg_i(side_c.w.neg),
    .a_i(side_c.vt.mag), .b_i(side_c.w.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_tw), .p_o(p_tw), .side_o()
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_vrw (
    .clk, .rst_n, .en, .vld_i(dv2_vld), .a_neg_i(side_c.vr.neg), .b_neg_i(side_c.w.neg),
    .a_i(side_c.vr.mag), .b_i(side_c.w.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_vrw), .p_o(p_vrw), .side_o()
  );

  // fraction alignment of the bank
  logic  s6_vld_r;
  st_d_t s6_r;
  sq_t   ar_r, az_r, tw_r, vrw_r, k0_r, k1_r, k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= m6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r  <= side_d;
      ar_r  <= quant(n_ar, p_ar);
      az_r  <= quant(n_az, p_az);
      tw_r  <= quant(n_tw, p_tw);
      vrw_r <= quant(n_vrw, p_vrw);
      k0_r  <= quant(n_k0, p_k0);
      k1_r  <= quant(n_k1, p_k1);
      k2_r  <= quant(n_k2, p_k2);
    end
  end

  // rates: centripetal minus gravity, negated coupling, negated gravity
  logic  s7_vld_r;
  sq_t   nar, rvr_nxt, rvt_nxt, rvz_nxt;
  sq_t   rvr_r, rvt_r, rvz_r;
  st_e_t s7_r, s7_nxt;
  sv_t   s7_h_r;

  always_comb begin
    nar        = negq(ar_r);
    rvr_nxt    = addq(tw_r, nar);
    rvt_nxt    = negq(vrw_r);
    rvz_nxt    = negq(az_r);
    s7_nxt.zr  = s6_r.zr;
    s7_nxt.sat = s6_r.sat | ar_r.sat | az_r.sat | tw_r.sat | vrw_r.sat | k0_r.sat
               | k1_r.sat | k2_r.sat | nar.sat | rvr_nxt.sat | rvt_nxt.sat
               | rvz_nxt.sat;
    s7_nxt.k0  = to_sv(k0_r);
    s7_nxt.k1  = to_sv(k1_r);
    s7_nxt.k2  = to_sv(k2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r   <= s7_nxt;
      s7_h_r <= s6_r.h;
      rvr_r  <= rvr_nxt;
      rvt_r  <= rvt_nxt;
      rvz_r  <= rvz_nxt;
    end
  end

  // step scaling of the three speed rates
  st_e_t          side_e;
  logic           m8_vld;
  logic           n_k3, n_k4, n_k5;
  logic [2*W-1:0] p_k3, p_k4, p_k5;

  orsi_mul #(.W(W), .SIDE_W($bits(st_e_t))) u_mul_k3 (
    .clk, .rst_n, .en, .vld_i(s7_vld_r), .a_neg_i(s7_h_r.neg), .b_neg_i(rvr_r.neg),
    .a_i(s7_h_r.mag), .b_i(rvr_r.mag), .side_i(s7_r),
    .vld_o(m8_vld), .neg_o(n_k3), .p_o(p_k3), .side_o(side_e)
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_k4 (
    .clk, .rst_n, .en, .vld_i(s7_vld_r), .a_neg_i(s7_h_r.neg), .b_neg_i(rvt_r.neg),
    .a_i(s7_h_r.mag), .b_i(rvt_r.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_k4), .p_o(p_k4), .side_o()
  );

  orsi_mul #(.W(W), .SIDE_W(1)) u_mul_k5 (
    .clk, .rst_n, .en, .vld_i(s7_vld_r), .a_neg_i(s7_h_r.neg), .b_neg_i(rvz_r.neg),
    .a_i(s7_h_r.mag), .b_i(rvz_r.mag), .side_i(1'b0),
    .vld_o(), .neg_o(n_k5), .p_o(p_k5), .side_o()
  );

  // output register: final alignment, two's complement, fault code
  sq_t              k3_q, k4_q, k5_q;
  logic             sat_all;
  logic             out_vld_r;
  logic [W-1:0]     k_rad_r, k_ang_r, k_hgt_r, k_vr_r, k_vt_r, k_vz_r;
  orsi_pkg::fault_t fault_r;

  always_comb begin
    k3_q    = quant(n_k3, p_k3);
    k4_q    = quant(n_k4, p_k4);
    k5_q    = quant(n_k5, p_k5);
    sat_all = side_e.sat | k3_q.sat | k4_q.sat | k5_q.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= m8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_e.zr) begin
        k_rad_r <= '0;
        k_ang_r <= '0;
        k_hgt_r <= '0;
        k_vr_r  <= '0;
        k_vt_r  <= '0;
        k_vz_r  <= '0;
        fault_r <= orsi_pkg::FAULT_ZERO_RADIUS;
      end else begin
        k_rad_r <= to_out({1'b0, side_e.k0});
        k_ang_r <= to_out({1'b0, side_e.k1});
        k_hgt_r <= to_out({1'b0, side_e.k2});
        k_vr_r  <= to_out(k3_q);
        k_vt_r  <= to_out(k4_q);
        k_vz_r  <= to_out(k5_q);
        fault_r <= sat_all ? orsi_pkg::FAULT_SATURATED : orsi_pkg::FAULT_OK;
      end
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.k_radius           = k_rad_r;
  assign out_ch.k_angle            = k_ang_r;
  assign out_ch.k_height           = k_hgt_r;
  assign out_ch.k_radial_speed     = k_vr_r;
  assign out_ch.k_tangential_speed = k_vt_r;
  assign out_ch.k_vertical_speed   = k_vz_r;
  assign out_ch.fault_code         = fault_r;

  // zero radius result carries no radius, angle, radial or vertical speed increment
  a_zero_radius_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (fault_r == orsi_pkg::FAULT_ZERO_RADIUS)) |->
      ((k_rad_r == '0) && (k_vr_r == '0) && (k_vz_r == '0) && (k_ang_r == '0)))
    else $error("zero radius result with nonzero increment");

  // a held output freezes the first stage too
  a_stall_holds_entry : assert property (@(posedge clk) disable iff (!rst_n)
    (!en && s0_vld_r) |=> (s0_vld_r && $stable(s0_r)))
    else $error("entry stage moved during stall");

  // no result straight out of reset
  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_vld_r && !s0_vld_r))
    else $error("valid bit survived reset");
endmodule
`default_nettype wire

FILE: tb/orbital_rate_step_increment_unit_test.sv
// orbital_rate_step_increment_unit_test: checks the rate step increment unit
// against a bit-exact sign-magnitude predictor, under random stalls on both channels
// depends on orsi_pkg, orsi_if and orbital_rate_step_increment_unit
`default_nettype none
module orbital_rate_step_increment_unit_test;

  localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct packed {
    logic [63:0] h;
    logic [62:0] r;
    logic [63:0] z;
    logic [63:0] vr;
    logic [63:0] vt;
    logic [63:0] vz;
  } orbit_state_t;

  typedef struct {
    logic [63:0]      k[6];
    orsi_pkg::fault_t fault;
  } increment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [62:0] cfg_wr_data = '0;

  orsi_in_if  #(.W(64)) in_ch ();
  orsi_out_if #(.W(64)) out_ch ();

  orbital_rate_step_increment_unit #(.WORD_BITS(64), .FRACTION_BITS(40)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #2 clk = ~clk;

  increment_t  pending_increments[$];
  logic [62:0] gm_copy = '0;
  logic        clamp_seen;
  int          mismatches = 0;
  int          hold_off = 0;
  logic        no_stalls = 1'b0;

  // ---------------- predictor ----------------
  function automatic smag_t clamp(input logic neg, input logic [63:0] mag, input logic over);
    logic [63:0] cap;
    cap = MAX_POS + {63'b0, neg};
    if (over || mag > cap) begin
      mag = cap;
      clamp_seen = 1'b1;
    end
    if (mag == 0) neg = 1'b0;
    return '{neg, mag};
  endfunction

  function automatic smag_t from_word(input logic [63:0] v);
    return clamp(v[63], v[63] ? -v : v, 1'b0);
  endfunction

  function automatic logic [63:0] to_word(input smag_t v);
    return v.neg ? -v.mag : v.mag;
  endfunction

  function automatic smag_t fx_mul(input smag_t a, input smag_t b);
    logic [127:0] p;
    p = 128'(a.mag) * 128'(b.mag);
    return clamp(a.neg ^ b.neg, p[103:40], p[127:104] != 0);
  endfunction

  function automatic smag_t fx_div(input smag_t a, input smag_t b);
    logic [127:0] q;
    if (b.mag == 0) return clamp(a.neg, 64'd0, 1'b1);
    q = {24'b0, a.mag, 40'b0} / 128'(b.mag);
    return clamp(a.neg ^ b.neg, q[63:0], q[127:64] != 0);
  endfunction

  function automatic smag_t fx_add(input smag_t a, input smag_t b);
    logic [64:0] s;
    if (a.neg == b.neg) begin
      s = 65'(a.mag) + 65'(b.mag);
      return clamp(a.neg, s[63:0], s[64]);
    end
    if (a.mag >= b.mag) return clamp(a.neg, a.mag - b.mag, 1'b0);
    return clamp(b.neg, b.mag - a.mag, 1'b0);
  endfunction

  function automatic smag_t fx_neg(input smag_t a);
    return clamp(~a.neg, a.mag, 1'b0);
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] s);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      c = res | (64'd1 << i);
      if (128'(c) * 128'(c) <= s) res = c;
    end
    return res;
  endfunction

  function automatic increment_t predict_increments(input orbit_state_t st);
    increment_t  e;
    smag_t       h, r, z, vr, vt, vz, gm, w, d, qr, qz, g1, g2, ar, az;
    smag_t       rate_vr, rate_vt, rate_vz;
    logic [127:0] sq;
    clamp_seen = 1'b0;
    h  = from_word(st.h);
    r  = clamp(1'b0, {1'b0, st.r}, 1'b0);
    z  = from_word(st.z);
    vr = from_word(st.vr);
    vt = from_word(st.vt);
    vz = from_word(st.vz);
    gm = clamp(1'b0, {1'b0, gm_copy}, 1'b0);
    // zero radius gives all-zero increments
    if (r.mag == 0) begin
      foreach (e.k[j]) e.k[j] = '0;
      e.fault = orsi_pkg::FAULT_ZERO_RADIUS;
      return e;
    end
    sq = 128'(r.mag) * 128'(r.mag) + 128'(z.mag) * 128'(z.mag);
    d = '{1'b0, root_floor(sq)};
    w  = fx_div(vt, r);
    qr = fx_div(r, d);
    qz = fx_div(z, d);
    g1 = fx_div(gm, d);
    g2 = fx_div(g1, d);
    ar = fx_mul(g2, qr);
    az = fx_mul(g2, qz);
    rate_vr = fx_add(fx_mul(vt, w), fx_neg(ar));
    rate_vt = fx_neg(fx_mul(vr, w));
    rate_vz = fx_neg(az);
    e.k[0] = to_word(fx_mul(h, vr));
    e.k[1] = to_word(fx_mul(h, w));
    e.k[2] = to_word(fx_mul(h, vz));
    e.k[3] = to_word(fx_mul(h, rate_vr));
    e.k[4] = to_word(fx_mul(h, rate_vt));
    e.k[5] = to_word(fx_mul(h, rate_vz));
    e.fault = clamp_seen ? orsi_pkg::FAULT_SATURATED : orsi_pkg::FAULT_OK;
    return e;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    if (no_stalls) return 0;
    if ($urandom_range(0, 99) < 3) return $urandom_range(20, 60);
    if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
    return 0;
  endfunction

  // moderate magnitudes below 2^22 in q23.40, random sign if allowed
  function automatic logic [63:0] modest_word(input logic allow_neg);
    logic [63:0] m;
    m = {32'b0, $urandom} << $urandom_range(8, 30);
    if (allow_neg && $urandom_range(0, 1)) m = -m;
    return m;
  endfunction

  function automatic orbit_state_t random_state();
    orbit_state_t st;
    logic [63:0]  t;
    logic [383:0] raw;
    if ($urandom_range(0, 99) < 20) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      st  = raw[$bits(orbit_state_t)-1:0];
    end else begin
      st.h  = modest_word(1'b1);
      t     = modest_word(1'b0);
      st.r  = t[62:0];
      st.z  = modest_word(1'b1);
      st.vr = modest_word(1'b1);
      st.vt = modest_word(1'b1);
      st.vz = modest_word(1'b1);
    end
    return st;
  endfunction

  // send one state item and record its expected increments at acceptance
  task automatic send_state(input orbit_state_t st);
    int gap;
    @(negedge clk);
    in_ch.valid            = 1'b1;
    in_ch.step_size        = st.h;
    in_ch.radius           = st.r;
    in_ch.height           = st.z;
    in_ch.radial_speed     = st.vr;
    in_ch.tangential_speed = st.vt;
    in_ch.vertical_speed   = st.vz;
    do @(posedge clk); while (!in_ch.ready);
    pending_increments.push_back(predict_increments(st));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_increments.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_gm(input logic [62:0] v);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    gm_copy     = v;
  endtask

  // ---------------- result side ----------------
  // ready with short and occasional long stalls, plus an explicit hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready = 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!no_stalls && $urandom_range(0, 99) < 25)
          stall_left = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    increment_t exp_inc;
    logic [63:0] got[6];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.k_radius, out_ch.k_angle, out_ch.k_height, out_ch.k_radial_speed,
              out_ch.k_tangential_speed, out_ch.k_vertical_speed};
      if (pending_increments.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        mismatches++;
      end else begin
        exp_inc = pending_increments.pop_front();
        foreach (got[j])
          if (got[j] !== exp_inc.k[j]) begin
            $display("%0t: increment %0d expected %h actual %h", $time, j,
                     exp_inc.k[j], got[j]);
            mismatches++;
          end
        if (out_ch.fault_code !== exp_inc.fault) begin
          $display("%0t: fault_code expected %0d actual %0d", $time, exp_inc.fault,
                   out_ch.fault_code);
          mismatches++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    orbit_state_t st;
    logic [63:0]  edge_words[4];
    edge_words = '{64'h8000_0000_0000_0000, MAX_POS, 64'd0, 64'hffff_ffff_ffff_ffff};
    load_gm(63'd1 << 40);
    // zero radius
    st = '{64'd1 << 40, 63'd0, 64'd1 << 40, 64'd5, 64'd7, 64'd9};
    send_state(st);
    // unit circular orbit
    st = '{64'd1 << 36, 63'd1 << 40, 64'd0, 64'd0, 64'd1 << 40, 64'd0};
    send_state(st);
    // field extremes in every slot
    foreach (edge_words[i]) begin
      st = '{edge_words[i], edge_words[i][62:0] | 63'd1, edge_words[i], edge_words[i],
             edge_words[i], edge_words[i]};
      send_state(st);
    end
    // smallest radius, huge height and speed: saturating divides
    st = '{MAX_POS, 63'd1, 64'h8000_0000_0000_0000, MAX_POS, MAX_POS, 64'd3};
    send_state(st);
    st = '{64'd1 << 40, {63{1'b1}}, 64'd0, 64'd1 << 40, 64'd1 << 40, 64'd1 << 40};
    send_state(st);
    load_gm({63{1'b1}});
    st = '{64'd1 << 40, 63'd1, 64'd1, 64'd0, 64'd0, 64'd0};
    send_state(st);
    st = '{-(64'd1 << 40), 63'd1 << 40, -(64'd1 << 40), 64'd1 << 38, -(64'd1 << 38), 64'd0};
    send_state(st);
    for (int i = 0; i < 6; i++) send_state(random_state());
  endtask

  task automatic test_random_gm(input logic [62:0] gm, input int count);
    load_gm(gm);
    for (int i = 0; i < count; i++) send_state(random_state());
  endtask

  task automatic test_backpressure();
    load_gm(63'd398 << 40);
    hold_off = 700;
    for (int i = 0; i < 300; i++) send_state(random_state());
  endtask

  task automatic test_no_stalls();
    no_stalls = 1'b1;
    for (int i = 0; i < 100; i++) send_state(random_state());
    drain();
    no_stalls = 1'b0;
  endtask

  initial begin
    in_ch.valid            = 1'b0;
    in_ch.step_size        = '0;
    in_ch.radius           = '0;
    in_ch.height           = '0;
    in_ch.radial_speed     = '0;
    in_ch.tangential_speed = '0;
    in_ch.vertical_speed   = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_gm(63'd0, 100);
    test_random_gm(63'({$urandom, $urandom}), 150);
    test_random_gm(63'd1 << 40, 150);
    test_backpressure();
    test_no_stalls();
    test_random_gm({63{1'b1}}, 130);
    drain();
    repeat (250) @(posedge clk);
    if (mismatches == 0 && pending_increments.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
sv/orsi_pkg.sv
sv/orsi_if.sv
sv/orsi_mul.sv
sv/orsi_div.sv
sv/orsi_sqrt.sv
sv/orbital_rate_step_increment_unit.sv
tb/orbital_rate_step_increment_unit_test.sv
